// ----- rtl/core/mscc_pkg.sv -----
// shared types, constants and the month start table for the calendar converter
// no dependencies; imported by mscc_split, mscc_build and the top level
package mscc_pkg;

    // number of register stages from item transfer to result
    localparam int unsigned STAGES = 9;

    // one day in milliseconds, and the same with its 2^10 factor taken out
    localparam logic [26:0] DAY_MS     = 27'd86400000;
    localparam logic [16:0] DAY_MS_ODD = 17'd84375;

    // reciprocals for exact division by constants: q = (x * R) >> S
    localparam int unsigned DAY_SHIFT  = 50;
    localparam logic [33:0] RECIP_DAY  = 34'(((64'd1 << 50) + 64'd84374) / 64'd84375);
    localparam int unsigned D1460_SHIFT = 29;
    localparam logic [18:0] RECIP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam int unsigned D365_SHIFT = 27;
    localparam logic [18:0] RECIP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam int unsigned D7_SHIFT   = 20;
    localparam logic [17:0] RECIP_7    = 18'(((64'd1 << 20) + 64'd6) / 64'd7);
    localparam int unsigned D153_SHIFT = 19;
    localparam logic [11:0] RECIP_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    // day number offsets relative to 1980-01-01 (era starts at 1600-03-01 and 2000-03-01)
    localparam logic [16:0] ERA5_START   = 17'd7365;
    localparam logic [17:0] ERA4_OFFSET  = 18'd138732;
    localparam logic [16:0] WDAY_OFFSET  = 17'd3655;

    // control from the top level: one load enable per register stage
    typedef logic [STAGES-1:0] stage_en_t;

    typedef struct packed {
        logic [7:0]  year_offset;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [26:0] ms_of_day;
        logic [2:0]  weekday;
        logic        range_error;
    } split_res_t;

    typedef struct packed {
        logic [42:0] elapsed_ms;
        logic        range_error;
    } build_res_t;

    // first day of a march-based month, counted from march 1st
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/mscc_split.sv -----
// millisecond count to calendar date datapath, nine register stages
// depends on mscc_pkg; stage enables come from the top level
module mscc_split (
    input  logic                    clk,
    input  mscc_pkg::stage_en_t     en,
    input  logic [42:0]             elapsed_ms,
    output mscc_pkg::split_res_t    res
);
    import mscc_pkg::*;

    // stage 1: split reciprocal product for the day count
    logic [32:0] s1_n_next;
    logic [49:0] s1_plo_next, s1_phi_next;
    logic [32:0] s1_n_reg;
    logic [9:0]  s1_lo_reg;
    logic [49:0] s1_plo_reg, s1_phi_reg;

    assign s1_n_next   = elapsed_ms[42:10];
    assign s1_plo_next = {17'd0, s1_n_next} * {33'd0, RECIP_DAY[16:0]};
    assign s1_phi_next = {17'd0, s1_n_next} * {33'd0, RECIP_DAY[33:17]};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_n_reg   <= s1_n_next;
            s1_lo_reg  <= elapsed_ms[9:0];
            s1_plo_reg <= s1_plo_next;
            s1_phi_reg <= s1_phi_next;
        end
    end

    // stage 2: sum partial products, take the day count
    logic [66:0] s2_sum_next;
    logic [16:0] s2_q_next, s2_q_reg;
    logic [32:0] s2_n_reg;
    logic [9:0]  s2_lo_reg;

    assign s2_sum_next = {s1_phi_reg, 17'd0} + {17'd0, s1_plo_reg};
    assign s2_q_next   = s2_sum_next[DAY_SHIFT +: 17];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_q_reg  <= s2_q_next;
            s2_n_reg  <= s1_n_reg;
            s2_lo_reg <= s1_lo_reg;
        end
    end

    // stage 3: remainder, era select, day of era, weekday quotient
    logic [33:0] s3_prod_next;
    logic [16:0] s3_r_next;
    logic        s3_era5_next, s3_era5_reg;
    logic [17:0] s3_doe_next, s3_doe_reg;
    logic [16:0] s3_v_next, s3_v_reg;
    logic [34:0] s3_p7_next;
    logic [26:0] s3_msday_reg;
    logic [14:0] s3_q7_reg;

    assign s3_prod_next = {17'd0, s2_q_reg} * {17'd0, DAY_MS_ODD};
    assign s3_r_next    = 17'({1'b0, s2_n_reg} - s3_prod_next);
    assign s3_era5_next = s2_q_reg >= ERA5_START;
    assign s3_doe_next  = s3_era5_next ? {1'b0, s2_q_reg - ERA5_START}
                                       : {1'b0, s2_q_reg} + ERA4_OFFSET;
    assign s3_v_next    = s2_q_reg + WDAY_OFFSET;
    assign s3_p7_next   = {18'd0, s3_v_next} * {17'd0, RECIP_7};

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_msday_reg <= {s3_r_next, s2_lo_reg};
            s3_era5_reg  <= s3_era5_next;
            s3_doe_reg   <= s3_doe_next;
            s3_v_reg     <= s3_v_next;
            s3_q7_reg    <= s3_p7_next[D7_SHIFT +: 15];
        end
    end

    // stage 4: weekday, century corrections of the day of era
    logic [36:0] s4_p1460_next;
    logic [2:0]  s4_c36_next, s4_c36_reg;
    logic [16:0] s4_rem7_next;
    logic [2:0]  s4_wday_reg;
    logic [7:0]  s4_q1460_reg;
    logic        s4_c146_reg, s4_era5_reg;
    logic [17:0] s4_doe_reg;
    logic [26:0] s4_msday_reg;

    assign s4_p1460_next = {19'd0, s3_doe_reg} * {18'd0, RECIP_1460};
    assign s4_rem7_next  = s3_v_reg - 17'({s3_q7_reg, 3'd0} - {3'd0, s3_q7_reg});
    always_comb
    begin
        if (s3_doe_reg >= 18'd146096)
            s4_c36_next = 3'd4;
        else if (s3_doe_reg >= 18'd109572)
            s4_c36_next = 3'd3;
        else if (s3_doe_reg >= 18'd73048)
            s4_c36_next = 3'd2;
        else if (s3_doe_reg >= 18'd36524)
            s4_c36_next = 3'd1;
        else
            s4_c36_next = 3'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_wday_reg  <= s4_rem7_next[2:0] + 3'd1;
            s4_q1460_reg <= s4_p1460_next[D1460_SHIFT +: 8];
            s4_c36_reg   <= s4_c36_next;
            s4_c146_reg  <= s3_doe_reg == 18'd146096;
            s4_era5_reg  <= s3_era5_reg;
            s4_doe_reg   <= s3_doe_reg;
            s4_msday_reg <= s3_msday_reg;
        end
    end

    // stage 5: leap-corrected day of era
    logic [17:0] s5_t_next, s5_t_reg, s5_doe_reg;
    logic        s5_era5_reg;
    logic [26:0] s5_msday_reg;
    logic [2:0]  s5_wday_reg;

    assign s5_t_next = s4_doe_reg - {10'd0, s4_q1460_reg} + {15'd0, s4_c36_reg}
                       - {17'd0, s4_c146_reg};

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_t_reg     <= s5_t_next;
            s5_doe_reg   <= s4_doe_reg;
            s5_era5_reg  <= s4_era5_reg;
            s5_msday_reg <= s4_msday_reg;
            s5_wday_reg  <= s4_wday_reg;
        end
    end

    // stage 6: year of era
    logic [36:0] s6_p365_next;
    logic [8:0]  s6_yoe_reg;
    logic [17:0] s6_doe_reg;
    logic        s6_era5_reg;
    logic [26:0] s6_msday_reg;
    logic [2:0]  s6_wday_reg;

    assign s6_p365_next = {19'd0, s5_t_reg} * {18'd0, RECIP_365};

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_yoe_reg   <= s6_p365_next[D365_SHIFT +: 9];
            s6_doe_reg   <= s5_doe_reg;
            s6_era5_reg  <= s5_era5_reg;
            s6_msday_reg <= s5_msday_reg;
            s6_wday_reg  <= s5_wday_reg;
        end
    end

    // stage 7: day of the march-based year
    logic [1:0]  s7_c100_next;
    logic [17:0] s7_sub_next, s7_doy_full_next;
    logic [8:0]  s7_doy_reg, s7_yoe_reg;
    logic        s7_era5_reg;
    logic [26:0] s7_msday_reg;
    logic [2:0]  s7_wday_reg;

    always_comb
    begin
        if (s6_yoe_reg >= 9'd300)
            s7_c100_next = 2'd3;
        else if (s6_yoe_reg >= 9'd200)
            s7_c100_next = 2'd2;
        else if (s6_yoe_reg >= 9'd100)
            s7_c100_next = 2'd1;
        else
            s7_c100_next = 2'd0;
    end
    assign s7_sub_next      = 18'({9'd0, s6_yoe_reg} * 18'd365) + {11'd0, s6_yoe_reg[8:2]}
                              - {16'd0, s7_c100_next};
    assign s7_doy_full_next = s6_doe_reg - s7_sub_next;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_doy_reg   <= s7_doy_full_next[8:0];
            s7_yoe_reg   <= s6_yoe_reg;
            s7_era5_reg  <= s6_era5_reg;
            s7_msday_reg <= s6_msday_reg;
            s7_wday_reg  <= s6_wday_reg;
        end
    end

    // stage 8: march-based month
    logic [10:0] s8_x_next;
    logic [22:0] s8_p153_next;
    logic [3:0]  s8_mp_reg;
    logic [8:0]  s8_doy_reg, s8_yoe_reg;
    logic        s8_era5_reg;
    logic [26:0] s8_msday_reg;
    logic [2:0]  s8_wday_reg;

    assign s8_x_next    = 11'({2'd0, s7_doy_reg} * 11'd5) + 11'd2;
    assign s8_p153_next = {12'd0, s8_x_next} * {11'd0, RECIP_153};

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s8_mp_reg    <= s8_p153_next[D153_SHIFT +: 4];
            s8_doy_reg   <= s7_doy_reg;
            s8_yoe_reg   <= s7_yoe_reg;
            s8_era5_reg  <= s7_era5_reg;
            s8_msday_reg <= s7_msday_reg;
            s8_wday_reg  <= s7_wday_reg;
        end
    end

    // stage 9: civil month, day, year offset and range check
    logic [8:0]  s9_dm_next;
    logic [3:0]  s9_m_next;
    logic [11:0] s9_yw_next;
    logic        s9_err_next;
    split_res_t  s9_res_next, s9_res_reg;

    assign s9_dm_next  = s8_doy_reg - month_start(s8_mp_reg) + 9'd1;
    assign s9_m_next   = (s8_mp_reg < 4'd10) ? s8_mp_reg + 4'd3 : s8_mp_reg - 4'd9;
    assign s9_yw_next  = {3'd0, s8_yoe_reg} + {11'd0, s9_m_next <= 4'd2}
                         + (s8_era5_reg ? 12'd20 : 12'd3716);
    assign s9_err_next = s9_yw_next > 12'd255;

    always_comb
    begin
        s9_res_next = '0;
        s9_res_next.range_error = s9_err_next;
        if (!s9_err_next)
        begin
            s9_res_next.year_offset = s9_yw_next[7:0];
            s9_res_next.month       = s9_m_next;
            s9_res_next.day         = s9_dm_next[4:0];
            s9_res_next.ms_of_day   = s8_msday_reg;
            s9_res_next.weekday     = s8_wday_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
            s9_res_reg <= s9_res_next;
    end

    assign res = s9_res_reg;

endmodule

// ----- rtl/core/mscc_build.sv -----
// calendar date to millisecond count datapath, three working stages then delay
// depends on mscc_pkg; stage enables come from the top level
module mscc_build (
    input  logic                    clk,
    input  mscc_pkg::stage_en_t     en,
    input  logic [7:0]              year_offset,
    input  logic [3:0]              month,
    input  logic [4:0]              day_of_month,
    input  logic [26:0]             ms_of_day,
    output mscc_pkg::build_res_t    res
);
    import mscc_pkg::*;

    // stage 1: march-based year, era and month
    logic        b1_mle2_next, b1_era5_next;
    logic [11:0] b1_y_next, b1_yoe_full_next;
    logic [3:0]  b1_mp_next;
    logic [8:0]  b1_yoe_reg, b1_mstart_reg;
    logic        b1_era5_reg;
    logic [4:0]  b1_day_reg;
    logic [26:0] b1_ms_reg;

    assign b1_mle2_next     = month <= 4'd2;
    assign b1_y_next        = 12'd1980 + {4'd0, year_offset} - {11'd0, b1_mle2_next};
    assign b1_era5_next     = b1_y_next >= 12'd2000;
    assign b1_yoe_full_next = b1_era5_next ? b1_y_next - 12'd2000 : b1_y_next - 12'd1600;
    assign b1_mp_next       = b1_mle2_next ? month + 4'd9 : month - 4'd3;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            b1_yoe_reg    <= b1_yoe_full_next[8:0];
            b1_era5_reg   <= b1_era5_next;
            b1_mstart_reg <= month_start(b1_mp_next);
            b1_day_reg    <= day_of_month;
            b1_ms_reg     <= ms_of_day;
        end
    end

    // stage 2: signed day count from 1980-01-01
    logic [1:0]  b2_c100_next;
    logic [19:0] b2_pos_next, b2_neg_next;
    logic [19:0] b2_days_reg;
    logic [26:0] b2_ms_reg;

    always_comb
    begin
        if (b1_yoe_reg >= 9'd300)
            b2_c100_next = 2'd3;
        else if (b1_yoe_reg >= 9'd200)
            b2_c100_next = 2'd2;
        else if (b1_yoe_reg >= 9'd100)
            b2_c100_next = 2'd1;
        else
            b2_c100_next = 2'd0;
    end
    assign b2_pos_next = 20'({11'd0, b1_yoe_reg} * 20'd365) + {13'd0, b1_yoe_reg[8:2]}
                         + {11'd0, b1_mstart_reg} + {15'd0, b1_day_reg}
                         + (b1_era5_reg ? {3'd0, ERA5_START} : 20'd0);
    assign b2_neg_next = {18'd0, b2_c100_next} + 20'd1
                         + (b1_era5_reg ? 20'd0 : {2'd0, ERA4_OFFSET});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b2_days_reg <= b2_pos_next - b2_neg_next;
            b2_ms_reg   <= b1_ms_reg;
        end
    end

    // stage 3: scale to milliseconds, flag dates before the epoch
    logic [43:0] b3_prod_next;
    logic [42:0] b3_sum_next;
    build_res_t  b3_res_next;
    build_res_t  dly_reg [3:STAGES];

    assign b3_prod_next = {10'd0, b2_days_reg[16:0]} * {17'd0, DAY_MS};
    assign b3_sum_next  = b3_prod_next[42:0] + {16'd0, b2_ms_reg};

    always_comb
    begin
        b3_res_next             = '0;
        b3_res_next.range_error = b2_days_reg[19];
        if (!b2_days_reg[19])
            b3_res_next.elapsed_ms = b3_sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            dly_reg[3] <= b3_res_next;
    end

    // remaining stages align with the date split path
    for (genvar k = 4; k <= STAGES; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en[k-1])
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    assign res = dly_reg[STAGES];

endmodule

// ----- rtl/core/ms_count_calendar_converter.sv -----
// Millisecond count / calendar date converter, counts from 1980-01-01 00:00.
// Item channel: item_valid / item_stall with opcode and both sets of date fields;
// opcode 0 splits elapsed_ms into year offset, month, day, ms of day and weekday
// (Monday 1 .. Sunday 7), opcode 1 builds out_elapsed_ms from the date fields.
// Result channel: result_valid / result_stall, one result per item, in order.
// Fields not produced by the opcode read as zero; range_error flags a count past
// year 2235 or a date before 1980, with all other fields zero.
// The pipeline has 9 register stages, set by the nine-stage date
// split path (reciprocal multiplies for the constant divisions); the build path
// is delayed to the same depth. It takes one item per cycle while item_stall
// is low.
// When the receiver stalls, the pipeline closes up its bubbles and only then
// raises item_stall; nothing is lost or repeated.
// Reset empties the pipeline; there is no configuration and no clearing pass.
// depends on mscc_pkg, mscc_split and mscc_build
module ms_count_calendar_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        opcode,
    input  logic [42:0] elapsed_ms,
    input  logic [7:0]  year_offset,
    input  logic [3:0]  month,
    input  logic [4:0]  day_of_month,
    input  logic [26:0] ms_of_day,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out_year_offset,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [26:0] out_ms_of_day,
    output logic [2:0]  weekday,
    output logic [42:0] out_elapsed_ms,
    output logic        range_error
);
    import mscc_pkg::*;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] op_reg, op_next;
    stage_en_t         en;
    split_res_t        split_res;
    build_res_t        build_res;

    // stage enables: a stage loads when empty or when the one after it moves
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign vld_next   = {vld_reg[STAGES-2:0], item_valid};
    assign op_next    = {op_reg[STAGES-2:0], opcode};
    assign item_stall = !en[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int k = 0; k < STAGES; k++)
                if (en[k])
                    vld_reg[k] <= vld_next[k];
        end
    end

    // opcode follows each transfer
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
            if (en[k])
                op_reg[k] <= op_next[k];
    end

    mscc_split u_split (
        .clk        (clk),
        .en         (en),
        .elapsed_ms (elapsed_ms),
        .res        (split_res)
    );

    mscc_build u_build (
        .clk          (clk),
        .en           (en),
        .year_offset  (year_offset),
        .month        (month),
        .day_of_month (day_of_month),
        .ms_of_day    (ms_of_day),
        .res          (build_res)
    );

    // result select by opcode
    assign result_valid    = vld_reg[STAGES-1];
    assign out_year_offset = op_reg[STAGES-1] ? 8'd0  : split_res.year_offset;
    assign out_month       = op_reg[STAGES-1] ? 4'd0  : split_res.month;
    assign out_day         = op_reg[STAGES-1] ? 5'd0  : split_res.day;
    assign out_ms_of_day   = op_reg[STAGES-1] ? 27'd0 : split_res.ms_of_day;
    assign weekday         = op_reg[STAGES-1] ? 3'd0  : split_res.weekday;
    assign out_elapsed_ms  = op_reg[STAGES-1] ? build_res.elapsed_ms : 43'd0;
    assign range_error     = op_reg[STAGES-1] ? build_res.range_error
                                              : split_res.range_error;

`ifndef NO_ASSERTIONS
    a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled with an empty output stage");

    a_error_clears_fields : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && range_error |-> out_month == 4'd0 && out_day == 5'd0
            && weekday == 3'd0 && out_elapsed_ms == 43'd0 && out_ms_of_day == 27'd0)
        else $error("range error with non-zero result fields");

    a_date_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && weekday != 3'd0 |-> out_month >= 4'd1 && out_month <= 4'd12
            && out_day != 5'd0 && out_elapsed_ms == 43'd0)
        else $error("split result with month or day out of range");

    a_ms_of_day_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> out_ms_of_day < DAY_MS)
        else $error("millisecond of day beyond one day");
`endif

endmodule
